// File: rtl/tbp_pkg.sv
// Package for the turtle bitmap plotter: grid constants, command codes, item types.
`timescale 1ns / 1ps

package tbp_pkg;

  localparam int GRID_SIZE = 32;
  // usable grid is clamped to the row width
  localparam int GRID_EFF  = (GRID_SIZE > 32) ? 32 : GRID_SIZE;
  localparam int NUM_ROWS  = 32;
  localparam int ROW_W     = 32;
  localparam int IDX_W     = 5;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GRID_EFF - 1);
  localparam logic [ROW_W-1:0] ROW_MASK =
    (GRID_EFF >= 32) ? {ROW_W{1'b1}} : ROW_W'((64'd1 << GRID_EFF) - 64'd1);

  localparam logic [3:0] CMD_PEN_UP   = 4'd0;
  localparam logic [3:0] CMD_PEN_DOWN = 4'd1;
  localparam logic [3:0] CMD_RIGHT    = 4'd2;
  localparam logic [3:0] CMD_LEFT     = 4'd3;
  localparam logic [3:0] CMD_FORWARD  = 4'd4;
  localparam logic [3:0] CMD_BACKWARD = 4'd5;
  localparam logic [3:0] CMD_INVERT   = 4'd6;
  localparam logic [3:0] CMD_ERASER   = 4'd7;
  localparam logic [3:0] CMD_PRINT    = 4'd8;

  localparam logic [1:0] HEAD_RIGHT = 2'd0;
  localparam logic [1:0] HEAD_DOWN  = 2'd1;
  localparam logic [1:0] HEAD_LEFT  = 2'd2;
  localparam logic [1:0] HEAD_UP    = 2'd3;

  typedef enum logic [1:0] {
    ROP_NONE,
    ROP_SET,
    ROP_CLR,
    ROP_INV
  } row_op_t;

  typedef struct packed {
    logic [3:0] cmd;
    logic [7:0] step_count;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_bits;
    logic             last_of_run;
    logic             off_grid;
    logic [IDX_W-1:0] pos_x;
    logic [IDX_W-1:0] pos_y;
    logic [1:0]       heading_now;
  } out_item_t;

endpackage

// File: rtl/turtle_bitmap_plotter_top.sv
// Turtle bitmap plotter: command sequencer around one shared row read-modify-write unit.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_ready   | tbp_pkg::in_item_t (cmd, step_count)
//   out_    | output    | out_valid/out_ready | tbp_pkg::out_item_t (row_bits .. heading_now)
//
// Pen, turn and unknown commands: S_IDLE accepts the command, then S_EMIT loads the status transfer.
// Move: S_MOVE then S_EMIT, one bitmap row updated per step through the row unit while pen or eraser is down.
// Invert: one row per cycle, then S_EMIT; print: one row transfer per cycle while the output is not stalled.
// A stalled output holds the sequencer in print and S_EMIT; in_ready is high only while the sequencer is idle.
// rst_n (synchronous) clears the whole bitmap, position, heading, pen, eraser and halt.
`timescale 1ns / 1ps

module turtle_bitmap_plotter_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tbp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tbp_pkg::out_item_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_INV,
    S_PRINT,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  logic [tbp_pkg::ROW_W-1:0] bitmap_r [tbp_pkg::NUM_ROWS];

  logic [tbp_pkg::IDX_W-1:0] col_r, col_nxt;
  logic [tbp_pkg::IDX_W-1:0] row_r, row_nxt;
  logic [1:0]                heading_r, heading_nxt;
  logic                      pen_r, pen_nxt;
  logic                      eraser_r, eraser_nxt;
  logic                      halted_r, halted_nxt;
  logic [1:0]                dir_r, dir_nxt;
  logic [7:0]                count_r, count_nxt;
  logic [tbp_pkg::IDX_W-1:0] walk_r, walk_nxt;

  logic                out_valid_r, out_valid_nxt;
  tbp_pkg::out_item_t  out_data_r, out_data_nxt;

  // shared row unit
  tbp_pkg::row_op_t           rop;
  logic [tbp_pkg::IDX_W-1:0]  rop_row;
  logic [tbp_pkg::IDX_W-1:0]  rop_col;
  logic [tbp_pkg::ROW_W-1:0]  rop_rd;
  logic [tbp_pkg::ROW_W-1:0]  rop_wr;
  logic [tbp_pkg::ROW_W-1:0]  rop_bit;

  logic in_fire;
  logic slot_free;
  logic at_edge;
  logic [tbp_pkg::IDX_W-1:0] step_col;
  logic [tbp_pkg::IDX_W-1:0] step_row;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rop_rd  = bitmap_r[rop_row];
  assign rop_bit = tbp_pkg::ROW_W'(1) << rop_col;

  always_comb begin
    case (rop)
      tbp_pkg::ROP_SET: rop_wr = rop_rd | rop_bit;
      tbp_pkg::ROP_CLR: rop_wr = rop_rd & ~rop_bit;
      tbp_pkg::ROP_INV: rop_wr = ~rop_rd & tbp_pkg::ROW_MASK;
      default:          rop_wr = rop_rd;
    endcase
  end

  // edge check and next cell for one step
  always_comb begin
    at_edge  = 1'b0;
    step_col = col_r;
    step_row = row_r;
    case (dir_r)
      tbp_pkg::HEAD_RIGHT: begin
        at_edge  = (col_r == tbp_pkg::LAST_IDX);
        step_col = col_r + 1'b1;
      end
      tbp_pkg::HEAD_DOWN: begin
        at_edge  = (row_r == tbp_pkg::LAST_IDX);
        step_row = row_r + 1'b1;
      end
      tbp_pkg::HEAD_LEFT: begin
        at_edge  = (col_r == '0);
        step_col = col_r - 1'b1;
      end
      default: begin
        at_edge  = (row_r == '0);
        step_row = row_r - 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    heading_nxt   = heading_r;
    pen_nxt       = pen_r;
    eraser_nxt    = eraser_r;
    halted_nxt    = halted_r;
    dir_nxt       = dir_r;
    count_nxt     = count_r;
    walk_nxt      = walk_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    rop           = tbp_pkg::ROP_NONE;
    rop_row       = row_r;
    rop_col       = col_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EMIT;
          if (!halted_r) begin
            case (in_data.cmd)
              tbp_pkg::CMD_PEN_UP: pen_nxt = 1'b0;
              tbp_pkg::CMD_PEN_DOWN: begin
                eraser_nxt = 1'b0;
                pen_nxt    = 1'b1;
                rop        = tbp_pkg::ROP_SET;
              end
              tbp_pkg::CMD_RIGHT: heading_nxt = heading_r + 2'd1;
              tbp_pkg::CMD_LEFT:  heading_nxt = heading_r + 2'd3;
              tbp_pkg::CMD_FORWARD: begin
                dir_nxt   = heading_r;
                count_nxt = in_data.step_count;
                state_nxt = S_MOVE;
              end
              tbp_pkg::CMD_BACKWARD: begin
                dir_nxt   = heading_r ^ 2'd2;
                count_nxt = in_data.step_count;
                state_nxt = S_MOVE;
              end
              tbp_pkg::CMD_INVERT: begin
                walk_nxt  = '0;
                state_nxt = S_INV;
              end
              tbp_pkg::CMD_ERASER: begin
                pen_nxt    = 1'b0;
                eraser_nxt = 1'b1;
                rop        = tbp_pkg::ROP_CLR;
              end
              tbp_pkg::CMD_PRINT: begin
                walk_nxt  = '0;
                state_nxt = S_PRINT;
              end
              default: ;
            endcase
          end
        end
      end

      S_MOVE: begin
        if (count_r == '0) begin
          state_nxt = S_EMIT;
        end else if (at_edge) begin
          halted_nxt = 1'b1;
          state_nxt  = S_EMIT;
        end else begin
          col_nxt   = step_col;
          row_nxt   = step_row;
          count_nxt = count_r - 8'd1;
          rop_row   = step_row;
          rop_col   = step_col;
          if (eraser_r) begin
            rop = tbp_pkg::ROP_CLR;
          end else if (pen_r) begin
            rop = tbp_pkg::ROP_SET;
          end
        end
      end

      S_INV: begin
        rop     = tbp_pkg::ROP_INV;
        rop_row = walk_r;
        if (walk_r == tbp_pkg::LAST_IDX) begin
          state_nxt = S_EMIT;
        end else begin
          walk_nxt = walk_r + 1'b1;
        end
      end

      S_PRINT: begin
        rop_row = walk_r;
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.row_bits    = rop_rd & tbp_pkg::ROW_MASK;
          out_data_nxt.last_of_run = (walk_r == tbp_pkg::LAST_IDX);
          out_data_nxt.off_grid    = halted_r;
          out_data_nxt.pos_x       = col_r;
          out_data_nxt.pos_y       = row_r;
          out_data_nxt.heading_now = heading_r;
          if (walk_r == tbp_pkg::LAST_IDX) begin
            state_nxt = S_IDLE;
          end else begin
            walk_nxt = walk_r + 1'b1;
          end
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.row_bits    = '0;
          out_data_nxt.last_of_run = 1'b1;
          out_data_nxt.off_grid    = halted_r;
          out_data_nxt.pos_x       = col_r;
          out_data_nxt.pos_y       = row_r;
          out_data_nxt.heading_now = heading_r;
          state_nxt                = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      heading_r   <= tbp_pkg::HEAD_RIGHT;
      pen_r       <= 1'b0;
      eraser_r    <= 1'b0;
      halted_r    <= 1'b0;
      dir_r       <= tbp_pkg::HEAD_RIGHT;
      count_r     <= '0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      heading_r   <= heading_nxt;
      pen_r       <= pen_nxt;
      eraser_r    <= eraser_nxt;
      halted_r    <= halted_nxt;
      dir_r       <= dir_nxt;
      count_r     <= count_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tbp_pkg::NUM_ROWS; i++) begin
        bitmap_r[i] <= '0;
      end
    end else if (rop != tbp_pkg::ROP_NONE) begin
      bitmap_r[rop_row] <= rop_wr;
    end
  end

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag cleared without reset");

  a_pos_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= tbp_pkg::LAST_IDX) && (row_r <= tbp_pkg::LAST_IDX))
    else $error("turtle position outside grid");

  a_halted_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && halted_r) |=> (state_r == S_EMIT))
    else $error("halted block started work on a command");

  a_mid_row_print: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.last_of_run) |-> (state_r == S_PRINT))
    else $error("non-final transfer outside print");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(out_data_r))
    else $error("pending transfer overwritten");
`endif

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the turtle bitmap plotter: directed script, random commands.
`timescale 1ns / 1ps

module testbench;

  localparam logic [3:0] CMD_UNUSED_FIRST = 4'd9;
  localparam logic [3:0] CMD_UNUSED_LAST  = 4'd15;
  localparam int SCRIPT_ROWS  = 25;
  localparam int PRE_ROWS     = 20;   // rows played before the random part, the rest after
  localparam int RANDOM_ITEMS = 405;
  localparam int HOLD_AFTER   = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    tbp_pkg::in_item_t  cmd_in;
    logic               typed;
    tbp_pkg::out_item_t want;
  } script_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  tbp_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  tbp_pkg::out_item_t out_data;

  // mirror of the plotter state
  logic [tbp_pkg::ROW_W-1:0] canvas [tbp_pkg::NUM_ROWS];
  int                        cur_x;
  int                        cur_y;
  logic [1:0]                cur_head;
  bit                        pen_on;
  bit                        erase_on;
  bit                        stopped;

  tbp_pkg::out_item_t due_rows [$];
  script_row_t        script [SCRIPT_ROWS];
  int                 errors;
  int                 accepted;
  int                 burst_left;

  turtle_bitmap_plotter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic tbp_pkg::out_item_t status_at(int x, int y, logic [1:0] h);
    tbp_pkg::out_item_t r;
    r = '0;
    r.last_of_run = 1'b1;
    r.pos_x = x[tbp_pkg::IDX_W-1:0];
    r.pos_y = y[tbp_pkg::IDX_W-1:0];
    r.heading_now = h;
    return r;
  endfunction

  function automatic void push_status();
    tbp_pkg::out_item_t r;
    r = status_at(cur_x, cur_y, cur_head);
    r.off_grid = stopped;
    due_rows.push_back(r);
  endfunction

  // a refused step leaves position and canvas alone and halts
  function automatic void plot_walk(logic [1:0] dir, int n);
    int nx, ny;
    for (int k = 0; k < n; k++) begin
      nx = cur_x;
      ny = cur_y;
      case (dir)
        tbp_pkg::HEAD_RIGHT: nx++;
        tbp_pkg::HEAD_DOWN:  ny++;
        tbp_pkg::HEAD_LEFT:  nx--;
        default:             ny--;
      endcase
      if (nx < 0 || ny < 0 || nx >= tbp_pkg::GRID_EFF || ny >= tbp_pkg::GRID_EFF) begin
        stopped = 1'b1;
        return;
      end
      cur_x = nx;
      cur_y = ny;
      if (pen_on) canvas[cur_y][cur_x] = 1'b1;
      if (erase_on) canvas[cur_y][cur_x] = 1'b0;
    end
  endfunction

  function automatic void plot_apply(tbp_pkg::in_item_t c);
    tbp_pkg::out_item_t r;
    if (stopped) begin
      push_status();
      return;
    end
    case (c.cmd)
      tbp_pkg::CMD_PEN_UP:   pen_on = 1'b0;
      tbp_pkg::CMD_PEN_DOWN: begin
        erase_on = 1'b0;
        pen_on = 1'b1;
        canvas[cur_y][cur_x] = 1'b1;
      end
      tbp_pkg::CMD_RIGHT:    cur_head = cur_head + 2'd1;
      tbp_pkg::CMD_LEFT:     cur_head = cur_head - 2'd1;
      tbp_pkg::CMD_FORWARD:  plot_walk(cur_head, c.step_count);
      tbp_pkg::CMD_BACKWARD: plot_walk(cur_head ^ 2'd2, c.step_count);
      tbp_pkg::CMD_INVERT: begin
        for (int i = 0; i < tbp_pkg::GRID_EFF; i++)
          canvas[i] = ~canvas[i] & tbp_pkg::ROW_MASK;
      end
      tbp_pkg::CMD_ERASER: begin
        pen_on = 1'b0;
        erase_on = 1'b1;
        canvas[cur_y][cur_x] = 1'b0;
      end
      tbp_pkg::CMD_PRINT: begin
        for (int i = 0; i < tbp_pkg::GRID_EFF; i++) begin
          r = status_at(cur_x, cur_y, cur_head);
          r.row_bits = canvas[i] & tbp_pkg::ROW_MASK;
          r.last_of_run = (i == tbp_pkg::GRID_EFF - 1);
          due_rows.push_back(r);
        end
        return;
      end
      default: ;
    endcase
    push_status();
  endfunction

  // sender: bursts of transfers separated by random gaps
  task automatic send_cmd(tbp_pkg::in_item_t c);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (!in_ready);
    accepted++;
    burst_left--;
    plot_apply(c);
  endtask

  task automatic play_row(int i);
    send_cmd(script[i].cmd_in);
    if (script[i].typed) due_rows[due_rows.size() - 1] = script[i].want;
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    tbp_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_rows.size() == 0) begin
        $display("%0t: unexpected transfer: expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        want = due_rows.pop_front();
        check_field("row_bits", want.row_bits, out_data.row_bits);
        check_field("last_of_run", 32'(want.last_of_run), 32'(out_data.last_of_run));
        check_field("off_grid", 32'(want.off_grid), 32'(out_data.off_grid));
        check_field("pos_x", 32'(want.pos_x), 32'(out_data.pos_x));
        check_field("pos_y", 32'(want.pos_y), 32'(out_data.pos_y));
        check_field("heading_now", 32'(want.heading_now), 32'(out_data.heading_now));
      end
    end
  end

  // receiver: stall pattern of its own, plus one long hold-off to back up the input
  initial begin
    int mode, len;
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && accepted >= HOLD_AFTER) begin
        @(posedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(5, 40);
      for (int k = 0; k < len; k++) begin
        @(posedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (k % 6 == 5);
        endcase
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin
    tbp_pkg::in_item_t c;
    int                pick, room;
    logic [1:0]        dir;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    errors = 0;
    accepted = 0;
    burst_left = 0;
    foreach (canvas[i]) canvas[i] = '0;
    cur_x = 0;
    cur_y = 0;
    cur_head = tbp_pkg::HEAD_RIGHT;
    pen_on = 1'b0;
    erase_on = 1'b0;
    stopped = 1'b0;

    script = '{
      '{'{tbp_pkg::CMD_PEN_UP,   8'd0},   1'b1, status_at(0, 0, tbp_pkg::HEAD_RIGHT)},
      '{'{tbp_pkg::CMD_PRINT,    8'd0},   1'b0, '0},
      '{'{CMD_UNUSED_LAST,       8'hff},  1'b1, status_at(0, 0, tbp_pkg::HEAD_RIGHT)},
      '{'{tbp_pkg::CMD_PEN_DOWN, 8'd0},   1'b1, status_at(0, 0, tbp_pkg::HEAD_RIGHT)},
      '{'{tbp_pkg::CMD_FORWARD,  8'd31},  1'b1, status_at(31, 0, tbp_pkg::HEAD_RIGHT)},
      '{'{tbp_pkg::CMD_RIGHT,    8'd0},   1'b1, status_at(31, 0, tbp_pkg::HEAD_DOWN)},
      '{'{tbp_pkg::CMD_FORWARD,  8'd31},  1'b1, status_at(31, 31, tbp_pkg::HEAD_DOWN)},
      '{'{tbp_pkg::CMD_FORWARD,  8'd0},   1'b1, status_at(31, 31, tbp_pkg::HEAD_DOWN)},
      '{'{tbp_pkg::CMD_LEFT,     8'd0},   1'b0, '0},
      '{'{tbp_pkg::CMD_LEFT,     8'd0},   1'b0, '0},
      '{'{tbp_pkg::CMD_LEFT,     8'd0},   1'b0, '0},
      '{'{tbp_pkg::CMD_FORWARD,  8'd10},  1'b0, '0},
      '{'{tbp_pkg::CMD_BACKWARD, 8'd4},   1'b0, '0},
      '{'{tbp_pkg::CMD_ERASER,   8'd0},   1'b0, '0},
      '{'{tbp_pkg::CMD_FORWARD,  8'd3},   1'b0, '0},
      '{'{tbp_pkg::CMD_PEN_UP,   8'd0},   1'b0, '0},   // eraser stays down
      '{'{tbp_pkg::CMD_FORWARD,  8'd2},   1'b0, '0},
      '{'{tbp_pkg::CMD_INVERT,   8'd0},   1'b0, '0},
      '{'{tbp_pkg::CMD_PRINT,    8'd0},   1'b0, '0},
      '{'{CMD_UNUSED_FIRST,      8'h80},  1'b0, '0},
      // run off the grid, then everything reports halted
      '{'{tbp_pkg::CMD_FORWARD,  8'd255}, 1'b0, '0},
      '{'{tbp_pkg::CMD_PRINT,    8'd0},   1'b0, '0},
      '{'{tbp_pkg::CMD_PEN_DOWN, 8'h55},  1'b0, '0},
      '{'{tbp_pkg::CMD_RIGHT,    8'haa},  1'b0, '0},
      '{'{CMD_UNUSED_LAST,       8'h7f},  1'b0, '0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PRE_ROWS; i++) play_row(i);

    // random commands; moves stay on the grid so the block keeps running
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      c.step_count = 8'($urandom_range(0, 255));
      if (pick < 40) begin
        c.cmd = (pick < 25) ? tbp_pkg::CMD_FORWARD : tbp_pkg::CMD_BACKWARD;
        dir = (pick < 25) ? cur_head : cur_head ^ 2'd2;
        case (dir)
          tbp_pkg::HEAD_RIGHT: room = tbp_pkg::GRID_EFF - 1 - cur_x;
          tbp_pkg::HEAD_DOWN:  room = tbp_pkg::GRID_EFF - 1 - cur_y;
          tbp_pkg::HEAD_LEFT:  room = cur_x;
          default:             room = cur_y;
        endcase
        c.step_count = 8'(($urandom_range(0, 3) == 0) ? room : $urandom_range(0, room));
      end else if (pick < 52) c.cmd = tbp_pkg::CMD_RIGHT;
      else if (pick < 62) c.cmd = tbp_pkg::CMD_LEFT;
      else if (pick < 72) c.cmd = tbp_pkg::CMD_PEN_DOWN;
      else if (pick < 80) c.cmd = tbp_pkg::CMD_PEN_UP;
      else if (pick < 88) c.cmd = tbp_pkg::CMD_ERASER;
      else if (pick < 92) c.cmd = tbp_pkg::CMD_INVERT;
      else if (pick < 96) c.cmd = tbp_pkg::CMD_PRINT;
      else c.cmd = CMD_UNUSED_FIRST + 4'($urandom_range(0, 6));
      send_cmd(c);
    end

    for (int i = PRE_ROWS; i < SCRIPT_ROWS; i++) play_row(i);
    in_valid <= 1'b0;

    while (due_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
rtl/tbp_pkg.sv
rtl/turtle_bitmap_plotter_top.sv
tb/testbench.sv
